// ===== rtl/core/pts_pkg.sv =====
// Shared types and constants for the periodic timer slot bank.
package pts_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int SLOT_COUNT_MAX = 32;

    localparam int OP_W     = 2;
    localparam int MS_W     = 32;
    localparam int IDX_W    = 3;
    localparam int MASK_W   = 8;
    localparam int TICK_W   = 64;
    localparam int PERIOD_W = 32;
    localparam int RATE_W   = 21;
    localparam int PROD_W   = MS_W + RATE_W;
    localparam int REM_W    = 10;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 80;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [RATE_W-1:0]   RATE_RESET = RATE_W'(1000);
    localparam logic [REM_W:0]      MS_PER_SEC = (REM_W + 1)'(1000);
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 2'd0,
        OP_REGISTER   = 2'd1,
        OP_UNREGISTER = 2'd2,
        OP_NONE       = 2'd3
    } op_t;

    localparam logic [0:0] REG_TICK_RATE = 1'b0;

endpackage

// ===== rtl/core/pts_conv.sv =====
// Millisecond to tick period converter: one multiply, then a reciprocal divide by 1000.
module pts_conv (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [pts_pkg::MS_W-1:0]           period_ms,
    input  logic [pts_pkg::RATE_W-1:0]         tick_rate_hz,
    output logic                               done,
    output logic [pts_pkg::PERIOD_W-1:0]       period
);

    localparam logic [pts_pkg::PROD_W-1:0] SAT_LIMIT =
        pts_pkg::PROD_W'(pts_pkg::MS_PER_SEC) << pts_pkg::PERIOD_W;

    // 1000 = 8 * 125: drop three bits, then multiply by ceil(2^46 / 125)
    localparam int DIV_SHIFT = 3;
    localparam int PART_W    = 20;
    localparam int RECIP_W   = 2 * PART_W;
    localparam int ACC_W     = 4 * PART_W;
    localparam int Q_LSB     = 46;
    localparam logic [RECIP_W-1:0] RECIP_125 = RECIP_W'(64'd562949953422);

    typedef enum logic [4:0] {
        C_IDLE  = 5'b00001,
        C_MUL   = 5'b00010,
        C_RECIP = 5'b00100,
        C_FIX   = 5'b01000,
        C_DONE  = 5'b10000
    } conv_state_t;

    conv_state_t                        state_reg, state_next;
    logic [pts_pkg::PROD_W-1:0]         prod_reg;
    logic [RECIP_W-1:0]                 dvd_reg;
    logic [ACC_W-1:0]                   acc_reg;
    logic [1:0]                         step_reg;
    logic [pts_pkg::PERIOD_W-1:0]       period_reg;

    logic [PART_W-1:0]                  mul_a;
    logic [PART_W-1:0]                  mul_b;
    logic [RECIP_W-1:0]                 mul_p;
    logic [ACC_W-1:0]                   addend;
    logic [pts_pkg::PERIOD_W-1:0]       quo;

    // one partial product per cycle: lo*lo, lo*hi, hi*lo, hi*hi
    assign mul_a = step_reg[1] ? dvd_reg[PART_W +: PART_W] : dvd_reg[PART_W-1:0];
    assign mul_b = step_reg[0] ? RECIP_125[PART_W +: PART_W] : RECIP_125[PART_W-1:0];
    assign mul_p = RECIP_W'(mul_a) * RECIP_W'(mul_b);
    assign quo   = acc_reg[Q_LSB +: pts_pkg::PERIOD_W];

    always_comb begin
        case (step_reg)
            2'd0:    addend = ACC_W'(mul_p);
            2'd3:    addend = ACC_W'(mul_p) << (2 * PART_W);
            default: addend = ACC_W'(mul_p) << PART_W;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE:  if (start) state_next = C_MUL;
            C_MUL:   state_next = (prod_reg >= SAT_LIMIT) ? C_DONE : C_RECIP;
            C_RECIP: if (step_reg == 2'd3) state_next = C_FIX;
            C_FIX:   state_next = C_DONE;
            C_DONE:  state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            C_IDLE: begin
                prod_reg <= pts_pkg::PROD_W'(period_ms) * pts_pkg::PROD_W'(tick_rate_hz);
            end
            C_MUL: begin
                // product is below 2^42 once saturation is ruled out
                dvd_reg    <= prod_reg[DIV_SHIFT +: RECIP_W];
                acc_reg    <= '0;
                step_reg   <= '0;
                period_reg <= pts_pkg::PERIOD_MAX;
            end
            C_RECIP: begin
                acc_reg  <= acc_reg + addend;
                step_reg <= step_reg + 2'd1;
            end
            C_FIX: begin
                period_reg <= (quo == '0) ? pts_pkg::PERIOD_W'(1) : quo;
            end
            default: begin
            end
        endcase
    end

    assign done   = (state_reg == C_DONE);
    assign period = period_reg;

endmodule

// ===== rtl/core/periodic_timer_slots.sv =====
// Top level of the periodic timer slot bank: sequencer, slot table and stream ports.
//
//  channel  | direction | payload (low bits first)
//  s_       | in        | operation[1:0], period_ms[33:2], slot_index[36:34]
//  m_       | out       | fired_mask[7:0], assigned_slot[10:8], table_full[11], tick_value[75:12]
//  APB      | in/out    | reg 0 at 0x0: tick_rate_hz[20:0]
//
// Tick: one slot compared per cycle, and reloaded when due. Register: accept, one search
// cycle per slot up to the first free one, the period converter (multiply, reciprocal
// partial products, fix; only the multiply when the period saturates), then write and finish.
// A full table skips the converter. Unregister and the unused code go straight to finish.
// s_tready is high only between words. A result waits in the output register; a stalled
// m_ side holds the next word in its last sequencer step. Reset is synchronous, clears all slots.
module periodic_timer_slots #(
    parameter int SLOT_COUNT = pts_pkg::SLOT_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // operation, period_ms, slot_index
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pts_pkg::S_DATA_W-1:0]    s_tdata,
    // fired_mask, assigned_slot, table_full, tick_value
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pts_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pts_pkg::APB_AW-1:0]      paddr,
    input  logic [pts_pkg::APB_DW-1:0]      pwdata,
    output logic [pts_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_TICK   = 6'b000010,
        S_SEARCH = 6'b000100,
        S_CONV   = 6'b001000,
        S_WRITE  = 6'b010000,
        S_FINISH = 6'b100000
    } seq_state_t;

    seq_state_t                         state_reg;
    logic [pts_pkg::TICK_W-1:0]         tick_cnt_reg;
    logic [pts_pkg::RATE_W-1:0]         rate_reg;
    logic [SLOT_COUNT-1:0]              slot_active_reg;
    logic [pts_pkg::PERIOD_W-1:0]       slot_period_reg [SLOT_COUNT];
    logic [pts_pkg::TICK_W-1:0]         slot_due_reg    [SLOT_COUNT];
    logic [SLOT_W-1:0]                  idx_reg;
    logic [pts_pkg::MS_W-1:0]           ms_reg;
    logic [SLOT_COUNT-1:0]              fire_vec_reg;
    logic [SLOT_W-1:0]                  assigned_reg;
    logic                               full_reg;
    logic                               m_tvalid_reg;
    logic [pts_pkg::M_DATA_W-1:0]       m_tdata_reg;

    logic                               in_fire;
    pts_pkg::op_t                       in_op;
    logic [pts_pkg::IDX_W-1:0]          in_idx;
    logic [SLOT_W+pts_pkg::IDX_W-1:0]   in_idx_ext;
    logic                               in_idx_ok;
    logic                               cfg_wr;
    logic                               conv_start;
    logic                               conv_done;
    logic [pts_pkg::PERIOD_W-1:0]       conv_period;
    logic [SLOT_W+pts_pkg::IDX_W-1:0]   assigned_ext;
    logic [pts_pkg::MASK_W-1:0]         fired_mask;
    logic                               out_free;
    logic                               slot_hit;

    assign in_fire    = s_tvalid && s_tready;
    assign in_op      = pts_pkg::op_t'(s_tdata[pts_pkg::OP_W-1:0]);
    assign in_idx     = s_tdata[pts_pkg::OP_W+pts_pkg::MS_W +: pts_pkg::IDX_W];
    assign in_idx_ext = {{SLOT_W{1'b0}}, in_idx};
    assign in_idx_ok  = (32'(in_idx) < 32'(SLOT_COUNT));
    assign s_tready   = (state_reg == S_IDLE);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign slot_hit   = slot_active_reg[idx_reg] && (tick_cnt_reg >= slot_due_reg[idx_reg]);
    assign conv_start = (state_reg == S_SEARCH) && !slot_active_reg[idx_reg];

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == pts_pkg::REG_TICK_RATE) ? pts_pkg::APB_DW'(rate_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= pts_pkg::RATE_RESET;
        end else if (cfg_wr && paddr[2] == pts_pkg::REG_TICK_RATE) begin
            rate_reg <= pwdata[pts_pkg::RATE_W-1:0];
        end
    end

    pts_conv u_conv (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (conv_start),
        .period_ms    (ms_reg),
        .tick_rate_hz (rate_reg),
        .done         (conv_done),
        .period       (conv_period)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            tick_cnt_reg    <= '0;
            slot_active_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (state_reg == S_FINISH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        case (in_op)
                            pts_pkg::OP_TICK: begin
                                tick_cnt_reg <= tick_cnt_reg + pts_pkg::TICK_W'(1);
                                state_reg    <= S_TICK;
                            end
                            pts_pkg::OP_REGISTER: begin
                                state_reg <= S_SEARCH;
                            end
                            pts_pkg::OP_UNREGISTER: begin
                                if (in_idx_ok) slot_active_reg[in_idx_ext[SLOT_W-1:0]] <= 1'b0;
                                state_reg <= S_FINISH;
                            end
                            default: begin
                                state_reg <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_TICK: begin
                    if (idx_reg == LAST_SLOT) state_reg <= S_FINISH;
                end
                S_SEARCH: begin
                    if (!slot_active_reg[idx_reg]) begin
                        state_reg <= S_CONV;
                    end else if (idx_reg == LAST_SLOT) begin
                        state_reg <= S_FINISH;
                    end
                end
                S_CONV: begin
                    if (conv_done) begin
                        slot_active_reg[idx_reg] <= 1'b1;
                        state_reg                <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    state_reg <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath: slot table, scan index, result flags
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                idx_reg      <= '0;
                ms_reg       <= s_tdata[pts_pkg::OP_W +: pts_pkg::MS_W];
                fire_vec_reg <= '0;
                assigned_reg <= '0;
                full_reg     <= 1'b0;
            end
            S_TICK: begin
                if (slot_hit) begin
                    fire_vec_reg[idx_reg] <= 1'b1;
                    slot_due_reg[idx_reg] <= tick_cnt_reg
                                             + pts_pkg::TICK_W'(slot_period_reg[idx_reg]);
                end
                idx_reg <= idx_reg + SLOT_W'(1);
            end
            S_SEARCH: begin
                if (!slot_active_reg[idx_reg]) begin
                    assigned_reg <= idx_reg;
                end else if (idx_reg == LAST_SLOT) begin
                    full_reg <= 1'b1;
                end else begin
                    idx_reg <= idx_reg + SLOT_W'(1);
                end
            end
            S_CONV: begin
                if (conv_done) slot_period_reg[idx_reg] <= conv_period;
            end
            S_WRITE: begin
                slot_due_reg[idx_reg] <= tick_cnt_reg
                                         + pts_pkg::TICK_W'(slot_period_reg[idx_reg]);
            end
            default: begin
            end
        endcase
    end

    // only slots below eight show in the mask
    genvar gi;
    generate
        for (gi = 0; gi < pts_pkg::MASK_W; gi++) begin : g_mask
            if (gi < SLOT_COUNT) begin : g_on
                assign fired_mask[gi] = fire_vec_reg[gi];
            end else begin : g_off
                assign fired_mask[gi] = 1'b0;
            end
        end
    endgenerate

    assign assigned_ext = {{pts_pkg::IDX_W{1'b0}}, assigned_reg};

    always_ff @(posedge aclk) begin
        if (state_reg == S_FINISH && out_free) begin
            m_tdata_reg <= {4'b0, tick_cnt_reg, full_reg,
                            assigned_ext[pts_pkg::IDX_W-1:0], fired_mask};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready)
        else $error("accepted a word while one is in work");

    a_conv_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_done |-> (state_reg == S_CONV))
        else $error("converter finished outside of a register operation");

    a_slot_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CONV && conv_done) |=> slot_active_reg[idx_reg])
        else $error("registered slot not marked active");

    a_cnt_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TICK) |=> $stable(tick_cnt_reg))
        else $error("tick counter moved during the slot scan");

endmodule

// ===== sim/tb_periodic_timer_slots.sv =====
// Self-checking stream testbench for the periodic timer slot bank.
`timescale 1ns / 1ps

module tb_periodic_timer_slots;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int SETTLE = 64;
    localparam int RANDOM_PER_PHASE = 380;
    localparam int PHASES = 5;
    localparam logic [pts_pkg::APB_AW-1:0] ADDR_TICK_RATE =
        pts_pkg::APB_AW'(4 * pts_pkg::REG_TICK_RATE);
    localparam logic [pts_pkg::APB_AW-1:0] ADDR_UNUSED = pts_pkg::APB_AW'(4);

    typedef struct {
        pts_pkg::op_t                   op;
        logic [pts_pkg::MS_W-1:0]       interval;
        logic [pts_pkg::IDX_W-1:0]      idx;
    } timer_req_t;

    // fired mask in the low bits, tick value on top
    typedef struct packed {
        logic [pts_pkg::TICK_W-1:0]  ticks;
        logic                        full;
        logic [pts_pkg::IDX_W-1:0]   slot;
        logic [pts_pkg::MASK_W-1:0]  fired;
    } timer_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [pts_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [pts_pkg::M_DATA_W-1:0] m_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [pts_pkg::APB_AW-1:0] paddr = '0;
    logic [pts_pkg::APB_DW-1:0] pwdata = '0;
    logic [pts_pkg::APB_DW-1:0] prdata;
    logic pready;

    // predicted state of the slot bank
    logic [pts_pkg::TICK_W-1:0]   tick_now = '0;
    logic [pts_pkg::RATE_W-1:0]   tick_rate = pts_pkg::RATE_RESET;
    logic                         slot_busy [pts_pkg::SLOT_COUNT_DEF];
    logic [pts_pkg::PERIOD_W-1:0] slot_len [pts_pkg::SLOT_COUNT_DEF];
    logic [pts_pkg::TICK_W-1:0]   slot_due_at [pts_pkg::SLOT_COUNT_DEF];

    timer_req_t  op_backlog [$];
    timer_word_t due_reports [$];
    timer_req_t  on_bus;
    timer_word_t rx_got, rx_want;

    int tx_gap = 0, tx_calm = 0, rx_gap = 0, rx_calm = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    logic hold_arm = 1'b0;
    logic m_hold = 1'b0;

    periodic_timer_slots dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // operation, period_ms, slot_index, zero fill
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // fired_mask, assigned_slot, table_full, tick_value, zero fill
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic note_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // mostly a random idle gap, with occasional runs of back-to-back words
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            calm = $urandom_range(20, 60);
        return $urandom_range(0, 16);
    endfunction

    function automatic timer_word_t advance_timers(input timer_req_t rq);
        timer_word_t w;
        logic [63:0] wide;
        logic found;
        w = '0;
        found = 1'b0;
        case (rq.op)
            pts_pkg::OP_TICK: begin
                tick_now = tick_now + 64'd1;
                for (int i = 0; i < pts_pkg::SLOT_COUNT_DEF; i++) begin
                    if (slot_busy[i] && tick_now >= slot_due_at[i]) begin
                        w.fired[i] = 1'b1;
                        slot_due_at[i] = tick_now + 64'(slot_len[i]);
                    end
                end
            end
            pts_pkg::OP_REGISTER: begin
                for (int i = 0; i < pts_pkg::SLOT_COUNT_DEF; i++) begin
                    if (!found && !slot_busy[i]) begin
                        found = 1'b1;
                        wide = (64'(rq.interval) * 64'(tick_rate))
                               / 64'(pts_pkg::MS_PER_SEC);
                        if (wide > 64'(pts_pkg::PERIOD_MAX))
                            slot_len[i] = pts_pkg::PERIOD_MAX;
                        else if (wide == 64'd0)
                            slot_len[i] = 32'd1;
                        else
                            slot_len[i] = wide[pts_pkg::PERIOD_W-1:0];
                        slot_busy[i] = 1'b1;
                        slot_due_at[i] = tick_now + 64'(slot_len[i]);
                        w.slot = pts_pkg::IDX_W'(i);
                    end
                end
                w.full = !found;
            end
            pts_pkg::OP_UNREGISTER: slot_busy[rq.idx] = 1'b0;
            default: ;
        endcase
        w.ticks = tick_now;
        return w;
    endfunction

    task automatic queue_op(input pts_pkg::op_t op, input logic [pts_pkg::MS_W-1:0] ms,
                            input logic [pts_pkg::IDX_W-1:0] idx);
        timer_req_t rq;
        rq.op = op;
        rq.interval = ms;
        rq.idx = idx;
        op_backlog.push_back(rq);
    endtask

    task automatic queue_random_op();
        timer_req_t rq;
        int pick;
        pick = $urandom_range(0, 19);
        rq.interval = $urandom;
        rq.idx = pts_pkg::IDX_W'($urandom_range(0, 7));
        if (pick < 11) begin
            rq.op = pts_pkg::OP_TICK;
        end else if (pick < 16) begin
            rq.op = pts_pkg::OP_REGISTER;
            // short periods of 0..12 ticks most of the time so slots keep firing
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    if (tick_rate != '0)
                        rq.interval = pts_pkg::MS_W'((64'($urandom_range(0, 12)) * 64'd1000
                                      + 64'($urandom_range(0, 999))) / 64'(tick_rate));
                end
                6: rq.interval = ($urandom_range(0, 1) != 0)
                                 ? 32'hFFFF_FFFF
                                 : pts_pkg::MS_W'($urandom_range(0, 1));
                default: ;
            endcase
        end else if (pick < 19) begin
            rq.op = pts_pkg::OP_UNREGISTER;
        end else begin
            rq.op = pts_pkg::OP_NONE;
        end
        op_backlog.push_back(rq);
    endtask

    task automatic apb_access(input logic wr, input logic [pts_pkg::APB_AW-1:0] addr,
                              input logic [pts_pkg::APB_DW-1:0] data,
                              output logic [pts_pkg::APB_DW-1:0] rdata);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_tick_rate(input logic [pts_pkg::APB_DW-1:0] value);
        logic [pts_pkg::APB_DW-1:0] readback;
        // unmapped register index: must leave the rate alone
        apb_access(1'b1, ADDR_UNUSED, $urandom, readback);
        apb_access(1'b1, ADDR_TICK_RATE, value, readback);
        tick_rate = value[pts_pkg::RATE_W-1:0];
        apb_access(1'b0, ADDR_TICK_RATE, '0, readback);
        if (readback !== pts_pkg::APB_DW'(tick_rate))
            note_mismatch($sformatf("tick_rate_hz read %h want %h", readback, tick_rate));
    endtask

    task automatic wait_drained();
        while (op_backlog.size() != 0 || s_tvalid || due_reports.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        for (int i = 0; i < pts_pkg::SLOT_COUNT_DEF; i++)
            slot_busy[i] = 1'b0;
    end

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                due_reports.push_back(advance_timers(on_bus));
                tx_gap = draw_gap(tx_calm);
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (op_backlog.size() != 0) begin
                    on_bus = op_backlog.pop_front();
                    s_tdata <= {3'b000, on_bus.idx, on_bus.interval, on_bus.op};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                rx_got = m_tdata[$bits(timer_word_t)-1:0];
                if (due_reports.size() == 0) begin
                    note_mismatch($sformatf("unexpected word %h", m_tdata));
                end else begin
                    rx_want = due_reports.pop_front();
                    if (rx_got.fired !== rx_want.fired)
                        note_mismatch($sformatf("fired_mask got %h want %h",
                                                rx_got.fired, rx_want.fired));
                    if (rx_got.slot !== rx_want.slot)
                        note_mismatch($sformatf("assigned_slot got %0d want %0d",
                                                rx_got.slot, rx_want.slot));
                    if (rx_got.full !== rx_want.full)
                        note_mismatch($sformatf("table_full got %b want %b",
                                                rx_got.full, rx_want.full));
                    if (rx_got.ticks !== rx_want.ticks)
                        note_mismatch($sformatf("tick_value got %0d want %0d",
                                                rx_got.ticks, rx_want.ticks));
                end
                rx_gap = draw_gap(rx_calm);
            end else if (rx_gap > 0) begin
                rx_gap--;
            end
            m_tready <= (rx_gap == 0) && !m_hold;
        end
    end

    // long receiver stall so the block backs up into its input
    initial begin
        wait (hold_arm);
        repeat (2000) @(posedge aclk);
        m_hold <= 1'b1;
        repeat (400) @(posedge aclk);
        m_hold <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [pts_pkg::APB_DW-1:0] phase_rate [PHASES];
        phase_rate[0] = 32'd1000;
        phase_rate[1] = 32'd19;
        phase_rate[2] = 32'd1193182;
        phase_rate[3] = 32'hFFE0_0000;   // rate field all zero, upper bits dropped
        phase_rate[4] = 32'hFFFF_FFFF;   // rate field all ones
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // zero period clamps to 1, full-scale interval, fill the table, overflow it
        queue_op(pts_pkg::OP_REGISTER, 32'd0, 3'd0);
        queue_op(pts_pkg::OP_REGISTER, 32'd1, 3'd0);
        queue_op(pts_pkg::OP_REGISTER, 32'hFFFF_FFFF, 3'd0);
        queue_op(pts_pkg::OP_REGISTER, 32'd3, 3'd0);
        queue_op(pts_pkg::OP_TICK, 32'd0, 3'd0);
        queue_op(pts_pkg::OP_TICK, 32'hFFFF_FFFF, 3'd7);
        queue_op(pts_pkg::OP_TICK, 32'd0, 3'd0);
        queue_op(pts_pkg::OP_UNREGISTER, 32'd0, 3'd2);
        queue_op(pts_pkg::OP_UNREGISTER, 32'd0, 3'd6);   // already free
        queue_op(pts_pkg::OP_NONE, 32'hFFFF_FFFF, 3'd7);
        queue_op(pts_pkg::OP_REGISTER, 32'd2, 3'd0);
        queue_op(pts_pkg::OP_REGISTER, 32'd1, 3'd0);
        queue_op(pts_pkg::OP_REGISTER, 32'd1, 3'd0);
        queue_op(pts_pkg::OP_REGISTER, 32'd1, 3'd0);
        queue_op(pts_pkg::OP_REGISTER, 32'd1, 3'd0);
        queue_op(pts_pkg::OP_REGISTER, 32'd5, 3'd0);     // no free slot left
        queue_op(pts_pkg::OP_TICK, 32'd0, 3'd0);
        queue_op(pts_pkg::OP_TICK, 32'd0, 3'd0);
        queue_op(pts_pkg::OP_UNREGISTER, 32'd0, 3'd7);
        queue_op(pts_pkg::OP_REGISTER, 32'd4, 3'd0);
        queue_op(pts_pkg::OP_TICK, 32'd0, 3'd0);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph != 0) begin
                wait_drained();
                repeat (SETTLE) @(posedge aclk);
                set_tick_rate(phase_rate[ph]);
            end else begin
                hold_arm = 1'b1;
            end
            repeat (RANDOM_PER_PHASE) queue_random_op();
        end

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0 && due_reports.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
